@@ rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u8u16_pkg;

  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  localparam logic [15:0] HighSurrogate = 16'hD800;
  localparam logic [15:0] LowSurrogate = 16'hDC00;
  localparam logic [20:0] SupplementaryBase = 21'h10000;

  // One queued record: the results that one input item causes.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two_units;
    logic        present;
    logic        end_flag;
    logic        invalid;
  } entry_t;

endpackage

@@ rtl/u8u16_front.sv @@
// Front end: accepts bytes, tracks the multi-byte sequence state and forms queue records.
// Depends on u8u16_pkg.
module u8u16_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  input  logic                queue_full,
  output logic                push,
  output u8u16_pkg::entry_t   push_entry
);

  logic [1:0]  pending_count, pending_count_next;
  logic [20:0] partial_code_point, partial_code_point_next;
  logic        error_seen, error_seen_next;
  logic        accept;
  logic        done;
  logic [20:0] code_point;
  logic [20:0] offset;

  assign in_stall = queue_full;
  assign accept = in_valid && !queue_full;

  always_comb begin
    pending_count_next = pending_count;
    partial_code_point_next = partial_code_point;
    error_seen_next = error_seen;
    done = 1'b0;
    code_point = 21'd0;
    if (!error_seen) begin
      if (pending_count == 2'd0) begin
        if (data_byte[7] == 1'b0) begin
          code_point = {13'd0, data_byte};
          done = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          partial_code_point_next = {16'd0, data_byte[4:0]};
          pending_count_next = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          partial_code_point_next = {17'd0, data_byte[3:0]};
          pending_count_next = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          partial_code_point_next = {18'd0, data_byte[2:0]};
          pending_count_next = 2'd3;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        error_seen_next = 1'b1;
      end else begin
        partial_code_point_next = {partial_code_point[14:0], data_byte[5:0]};
        pending_count_next = pending_count - 2'd1;
        if (pending_count == 2'd1) begin
          code_point = {partial_code_point[14:0], data_byte[5:0]};
          done = 1'b1;
        end
      end
    end
  end

  assign offset = code_point - u8u16_pkg::SupplementaryBase;

  always_comb begin
    push_entry = '0;
    push = accept && (done || final_byte);
    if (done) begin
      push_entry.present = 1'b1;
      push_entry.end_flag = final_byte;
      if (code_point[20:16] == 5'd0) begin
        push_entry.unit0 = code_point[15:0];
      end else begin
        push_entry.two_units = 1'b1;
        push_entry.unit0 = u8u16_pkg::HighSurrogate | {5'd0, offset[20:10]};
        push_entry.unit1 = u8u16_pkg::LowSurrogate | {6'd0, offset[9:0]};
      end
    end else begin
      push_entry.end_flag = 1'b1;
      push_entry.invalid = error_seen_next || (pending_count_next != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      partial_code_point <= 21'd0;
      error_seen <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        pending_count <= 2'd0;
        partial_code_point <= 21'd0;
        error_seen <= 1'b0;
      end else begin
        pending_count <= pending_count_next;
        partial_code_point <= partial_code_point_next;
        error_seen <= error_seen_next;
      end
    end
  end

endmodule

@@ rtl/u8u16_queue.sv @@
// Short queue of result records between the front and back ends.
// Depends on u8u16_pkg.
module u8u16_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output u8u16_pkg::entry_t head
);

  u8u16_pkg::entry_t                 slots [u8u16_pkg::QueueDepth];
  logic [u8u16_pkg::PtrW-1:0]        wr_ptr;
  logic [u8u16_pkg::PtrW-1:0]        rd_ptr;
  logic [u8u16_pkg::CountW-1:0]      count;
  logic                              do_push;
  logic                              do_pop;

  assign full = (count == u8u16_pkg::CountW'(u8u16_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + u8u16_pkg::PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + u8u16_pkg::PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + u8u16_pkg::CountW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - u8u16_pkg::CountW'(1);
      end
    end
  end

endmodule

@@ rtl/u8u16_back.sv @@
// Back end: turns each queued record into one or two output items.
// Depends on u8u16_pkg.
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  u8u16_pkg::entry_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       code_unit,
  output logic              unit_present,
  output logic              end_of_buffer,
  output logic              buffer_invalid,
  output logic              run_last
);

  logic second;
  logic second_next;
  logic taken;
  logic last_of_entry;

  assign out_valid = not_empty;
  assign taken = not_empty && !out_stall;
  assign last_of_entry = second || !head.two_units;
  assign pop = taken && last_of_entry;

  assign code_unit = second ? head.unit1 : head.unit0;
  assign unit_present = head.present;
  assign end_of_buffer = head.end_flag && last_of_entry;
  assign buffer_invalid = head.invalid;
  assign run_last = last_of_entry;

  always_comb begin
    second_next = second;
    if (taken) begin
      second_next = !last_of_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

endmodule

@@ rtl/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
// Input channel: one UTF-8 byte per item on data_byte, with final_byte set on
// the last byte of a buffer; in_valid and in_stall form the handshake.
// Output channel: one UTF-16 unit per item with its flags; out_valid and
// out_stall form the handshake. The final byte of every buffer yields an item
// with end_of_buffer set, and buffer_invalid on it tells the consumer to drop
// the units of that buffer. run_last marks the last item caused by a byte.
// Each accepted byte's record is registered in the queue before its first output item.
// A byte is accepted every cycle while the four-record queue has room; a byte
// that decodes to a surrogate pair yields two output items, so absent stalls
// the sustained rate is one byte per cycle for any valid stream.
// Reset clears the sequence state and empties the queue. When the receiver
// stalls, the current output item holds and the queue fills; in_stall rises
// once it is full.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        unit_present,
  output logic        end_of_buffer,
  output logic        buffer_invalid,
  output logic        run_last
);

  logic              push;
  logic              full;
  logic              pop;
  logic              not_empty;
  u8u16_pkg::entry_t push_entry;
  u8u16_pkg::entry_t head;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  u8u16_back u_back (
    .clk            (clk),
    .rst            (rst),
    .not_empty      (not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_unit      (code_unit),
    .unit_present   (unit_present),
    .end_of_buffer  (end_of_buffer),
    .buffer_invalid (buffer_invalid),
    .run_last       (run_last)
  );

endmodule
